// ----- src/dttf_pkg.sv -----
// dttf_pkg: shared types, character codes and the divide-by-ten helper
// for the decimal text to fixed-point parser. No dependencies.
`timescale 1ns / 1ps

package dttf_pkg;

	// Widths
	localparam int MANT_W        = 64;
	localparam int CHUNK_W       = 16;
	localparam int NIB_PER_CHUNK = CHUNK_W / 4;
	localparam int K_W           = 6;

	// Parser limits
	localparam int          FRAC_BITS_DEF = 16;
	localparam logic [4:0]  MAX_DIGITS    = 5'd18;
	localparam logic [4:0]  MAX_EXPONENT  = 5'd15;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EXP   = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	// Divider command and status between the parser and the divide unit
	typedef struct packed {
		logic           start;
		logic [K_W-1:0] k;
	} dttf_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dttf_sts_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] q;
		logic [3:0]         rem;
	} div_step_t;

	// Width of the divide register: mantissa plus fraction bits, whole chunks
	function automatic int work_width(input int frac_bits);
		return ((MANT_W + frac_bits + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
	endfunction

	// One chunk of long division by ten, a nibble at a time from the top.
	// The nibble quotient uses x*205>>11, exact for x below 1029.
	function automatic div_step_t div10_chunk(input logic [3:0] rem_in,
			input logic [CHUNK_W-1:0] chunk);
		div_step_t  res;
		logic [3:0] r;
		logic [7:0] cur;
		logic [15:0] prod;
		logic [3:0] qn;
		res   = '0;
		r     = rem_in;
		for (int i = NIB_PER_CHUNK - 1; i >= 0; i--) begin
			cur  = {r, chunk[i*4 +: 4]};
			prod = 16'(cur) * 16'd205;
			qn   = prod[14:11];
			res.q[i*4 +: 4] = qn;
			r    = 4'(cur - 8'(qn) * 8'd10);
		end
		res.rem = r;
		return res;
	endfunction

endpackage

// ----- src/dttf_div10.sv -----
// dttf_div10: iterative divide of mantissa*2^FRAC_BITS by 10^k, one
// 16-bit chunk per cycle through a shared divide-by-ten step. Uses dttf_pkg.
`timescale 1ns / 1ps

module dttf_div10 #(
	parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dttf_pkg::dttf_cmd_t                     cmd,
	input  logic [dttf_pkg::MANT_W-1:0]             mant,
	output dttf_pkg::dttf_sts_t                     sts,
	output logic [dttf_pkg::work_width(FRAC_BITS)-1:0] quo
);
	import dttf_pkg::*;

	localparam int WX     = work_width(FRAC_BITS);
	localparam int NCHUNK = WX / CHUNK_W;
	localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic [WX-1:0]    x_q;
	logic [3:0]       rem_q;
	logic [CNT_W-1:0] chunk_q;
	logic [K_W-1:0]   div_cnt_q;
	logic             busy_q;
	logic             done_q;
	div_step_t        step;

	// Shared step: top chunk of the working value
	assign step = div10_chunk(rem_q, x_q[WX-1 -: CHUNK_W]);

	// Rotate the value left one chunk per cycle, quotient enters at the bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			rem_q     <= '0;
			chunk_q   <= '0;
			div_cnt_q <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				x_q       <= WX'({mant, {FRAC_BITS{1'b0}}});
				rem_q     <= '0;
				chunk_q   <= '0;
				div_cnt_q <= cmd.k;
				busy_q    <= (cmd.k != '0);
				done_q    <= (cmd.k == '0);
			end else if (busy_q) begin
				x_q <= {x_q[WX-CHUNK_W-1:0], step.q};
				if (chunk_q == CNT_W'(NCHUNK - 1)) begin
					chunk_q <= '0;
					rem_q   <= '0;
					if (div_cnt_q == K_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					div_cnt_q <= div_cnt_q - K_W'(1);
				end else begin
					chunk_q <= chunk_q + CNT_W'(1);
					rem_q   <= step.rem;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = x_q;

	// Checks
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (busy_q || done_q))
		else $error("divider did not take start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_chunk_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (int'(chunk_q) < NCHUNK))
		else $error("chunk counter out of range");

endmodule

// ----- src/decimal_text_to_fixed_unit.sv -----
// decimal_text_to_fixed_unit: streaming ASCII decimal parser, signed Q15.16
// result. Depends on dttf_pkg and dttf_div10.
`timescale 1ns / 1ps
//
//  channel | dir | tdata                         | tuser
//  s_axis  | in  | [7:0] text_char               | -
//  m_axis  | out | [31:0] value, [39:32] end_char| [0] saturated
//
// A character that continues a number is taken without stalling the input.
// A character that ends a number starts a divide by 10^k, k = fraction digits
// plus exponent, in the chunk-serial divide-by-ten unit over NCHUNK = 16-bit
// chunks of the divide register (5 at 16 fraction bits); input stalls meanwhile.
// Reset clears parser and control state; there is no clearing pass.
// The result register holds a word until taken; input continues meanwhile, and
// a following number end waits for the register to free.

module decimal_text_to_fixed_unit #(
	parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] value, [39:32] end_char
	output logic        m_axis_tuser    // [0] saturated
);
	import dttf_pkg::*;

	localparam int WX = work_width(FRAC_BITS);

	typedef enum logic [1:0] {S_IN, S_DIV, S_DONE} state_t;
	typedef enum logic [2:0] {PH_WS, PH_INT, PH_FRAC, PH_ESKIP, PH_EXP} phase_t;

	state_t             state_q;
	phase_t             phase_q, phase_c;
	logic               neg_q, neg_c;
	logic [MANT_W-1:0]  mant_q, mant_c;
	logic [4:0]         frac_q, frac_c;
	logic [4:0]         exp_q, exp_c;
	logic               ovf_q, ovf_c;
	logic               finish_c;

	logic               res_neg_q;
	logic               res_ovf_q;
	logic [7:0]         res_char_q;

	logic               out_valid_q;
	logic [31:0]        out_value_q;
	logic               out_sat_q;
	logic [7:0]         out_char_q;

	logic [7:0]         ch;
	logic               in_acc;
	logic               is_sp, is_dig;
	logic [3:0]         dig;
	logic [MANT_W+3:0]  mant_x10;
	logic [8:0]         exp_x10;

	dttf_cmd_t          div_cmd;
	dttf_sts_t          div_sts;
	logic [WX-1:0]      quo;

	logic [31:0]        limit_c;
	logic               sat_c;
	logic [31:0]        mag_c;

	assign ch     = s_axis_tdata;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IN);

	// Character classes and the digit accumulators
	assign is_sp    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dig      = 4'(ch - CH_ZERO);
	assign mant_x10 = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + (MANT_W+4)'(dig);
	assign exp_x10  = {1'b0, exp_q, 3'b000} + {3'b000, exp_q, 1'b0} + 9'(dig);

	// Parser next state for the current character
	always_comb begin
		phase_c  = phase_q;
		neg_c    = neg_q;
		mant_c   = mant_q;
		frac_c   = frac_q;
		exp_c    = exp_q;
		ovf_c    = ovf_q;
		finish_c = 1'b0;
		case (phase_q)
			PH_WS: begin
				if (is_sp) begin
					phase_c = PH_WS;
				end else if (ch == CH_MINUS) begin
					neg_c   = 1'b1;
					phase_c = PH_INT;
				end else if (ch == CH_PLUS) begin
					phase_c = PH_INT;
				end else if (is_dig) begin
					if (mant_x10[MANT_W+3:MANT_W] != '0) ovf_c = 1'b1;
					else mant_c = mant_x10[MANT_W-1:0];
					phase_c = PH_INT;
				end else if (ch == CH_DOT) begin
					phase_c = PH_FRAC;
				end else begin
					finish_c = 1'b1;
				end
			end
			PH_INT: begin
				if (is_dig) begin
					if (mant_x10[MANT_W+3:MANT_W] != '0) ovf_c = 1'b1;
					else mant_c = mant_x10[MANT_W-1:0];
				end else if (ch == CH_DOT) begin
					phase_c = PH_FRAC;
				end else begin
					finish_c = 1'b1;
				end
			end
			PH_FRAC: begin
				if (is_dig) begin
					if (frac_q < MAX_DIGITS) begin
						if (mant_x10[MANT_W+3:MANT_W] != '0) ovf_c = 1'b1;
						else mant_c = mant_x10[MANT_W-1:0];
						frac_c = frac_q + 5'd1;
					end
				end else if (ch == CH_EXP) begin
					phase_c = PH_ESKIP;
				end else begin
					finish_c = 1'b1;
				end
			end
			PH_ESKIP: begin
				phase_c = PH_EXP;
			end
			PH_EXP: begin
				if (is_dig) begin
					exp_c = (exp_x10 > 9'(MAX_EXPONENT)) ? MAX_EXPONENT : exp_x10[4:0];
				end else begin
					finish_c = 1'b1;
				end
			end
			default: begin
				finish_c = 1'b1;
			end
		endcase
	end

	// Divide request on a number end
	assign div_cmd.start = in_acc && finish_c;
	assign div_cmd.k     = K_W'(frac_q) + K_W'(exp_q);

	dttf_div10 #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (div_cmd),
		.mant  (mant_q),
		.sts   (div_sts),
		.quo   (quo)
	);

	// Clamp, sign and result formatting
	assign limit_c = res_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign sat_c   = res_ovf_q || (quo > WX'(limit_c));
	assign mag_c   = sat_c ? limit_c : quo[31:0];

	// Sequencer, parser registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IN;
			phase_q     <= PH_WS;
			neg_q       <= 1'b0;
			mant_q      <= '0;
			frac_q      <= '0;
			exp_q       <= '0;
			ovf_q       <= 1'b0;
			res_neg_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
			res_char_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_sat_q   <= 1'b0;
			out_char_q  <= '0;
		end else begin
			// a word taken while a new one loads is handled in S_DONE
			if (out_valid_q && m_axis_tready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IN: begin
					if (in_acc) begin
						if (finish_c) begin
							res_neg_q  <= neg_q;
							res_ovf_q  <= ovf_q;
							res_char_q <= ch;
							phase_q    <= PH_WS;
							neg_q      <= 1'b0;
							mant_q     <= '0;
							frac_q     <= '0;
							exp_q      <= '0;
							ovf_q      <= 1'b0;
							state_q    <= S_DIV;
						end else begin
							phase_q <= phase_c;
							neg_q   <= neg_c;
							mant_q  <= mant_c;
							frac_q  <= frac_c;
							exp_q   <= exp_c;
							ovf_q   <= ovf_c;
						end
					end
				end
				S_DIV: begin
					if (div_sts.done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_neg_q ? (32'd0 - mag_c) : mag_c;
						out_sat_q   <= sat_c;
						out_char_q  <= res_char_q;
						state_q     <= S_IN;
					end
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_char_q, out_value_q};
	assign m_axis_tuser  = out_sat_q;

	// Checks
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIV))
		else $error("divide finished outside the divide state");
	a_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == S_DIV))
		else $error("divider busy outside the divide state");
	a_start_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |=> (state_q == S_DIV))
		else $error("number end did not start the divide");
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000))
		else $error("saturated word not at a limit");
	a_frac_limit: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= MAX_DIGITS)
		else $error("fraction digit count past limit");

endmodule

// ----- tb/tb_decimal_text_to_fixed_unit.sv -----
// tb_decimal_text_to_fixed_unit: self-checking bench for the streaming decimal
// text to Q15.16 parser. Needs dttf_pkg, dttf_div10 and decimal_text_to_fixed_unit.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_unit;
	import dttf_pkg::*;

	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int TEXT_CHARS   = 1100;  // characters that reach the parser
	localparam int CALM_CHARS   = 100;   // final stretch with no idling
	localparam int DRAIN_CYCLES = 200;   // worst number end divides by 10^33
	localparam int STALL_LIMIT  = 3000;  // cycles with no word moving

	// Whitespace and other codes not in the package
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [2:0] {
		PH_SPACE, PH_INT, PH_FRAC, PH_ESKIP, PH_EXP
	} parse_phase_t;

	typedef struct {
		logic [31:0] value;
		logic        saturated;
		logic [7:0]  end_char;
	} number_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	decimal_text_to_fixed_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Parser shadow state
	parse_phase_t ph       = PH_SPACE;
	logic         neg      = 1'b0;
	logic [63:0]  mant     = '0;
	logic [4:0]   frac_cnt = '0;
	logic [4:0]   exp_val  = '0;
	logic         ovf      = 1'b0;

	number_t expected_numbers[$];
	int      errors       = 0;
	int      chars_used   = 0;
	int      numbers_seen = 0;
	int      sat_count    = 0;
	int      deepest_k    = 0;
	int      idle_cycles  = 0;
	bit      calm         = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Append one decimal digit, dropping it if the mantissa would wrap
	task automatic push_digit(input logic [3:0] d);
		if (mant > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10)
			ovf = 1'b1;
		else
			mant = mant * 64'd10 + 64'(d);
	endtask

	// Number end: scale, divide by 10^k with truncation, clamp, apply sign
	task automatic close_number(input logic [7:0] c);
		logic [127:0] acc;
		logic [63:0]  mag;
		logic [63:0]  limit;
		logic         sat;
		number_t      n;
		int           k;
		acc = {64'd0, mant} << FRAC_BITS;
		k   = int'(frac_cnt) + int'(exp_val);
		for (int i = 0; i < k; i++)
			acc = acc / 128'd10;
		limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		mag   = acc[63:0];
		sat   = ovf || (acc[127:64] != '0) || (mag > limit);
		if (sat)
			mag = limit;
		n.value     = neg ? -mag[31:0] : mag[31:0];
		n.saturated = sat;
		n.end_char  = c;
		expected_numbers.push_back(n);
		if (sat)
			sat_count++;
		if (k > deepest_k)
			deepest_k = k;
		ph       = PH_SPACE;
		neg      = 1'b0;
		mant     = '0;
		frac_cnt = '0;
		exp_val  = '0;
		ovf      = 1'b0;
	endtask

	// Advance the shadow parser by one accepted character
	task automatic parse_char(input logic [7:0] c);
		logic       is_sp;
		logic       is_dig;
		logic [3:0] d;
		logic [7:0] e;
		is_sp  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d      = 4'(c - CH_ZERO);
		chars_used++;
		case (ph)
			PH_SPACE: begin
				if (!is_sp) begin
					if (c == CH_MINUS) begin
						neg = 1'b1;
						ph  = PH_INT;
					end else if (c == CH_PLUS) begin
						ph = PH_INT;
					end else if (is_dig) begin
						push_digit(d);
						ph = PH_INT;
					end else if (c == CH_DOT) begin
						ph = PH_FRAC;
					end else begin
						close_number(c);
					end
				end
			end
			PH_INT: begin
				if (is_dig)
					push_digit(d);
				else if (c == CH_DOT)
					ph = PH_FRAC;
				else
					close_number(c);
			end
			PH_FRAC: begin
				if (is_dig) begin
					if (frac_cnt < MAX_DIGITS) begin
						push_digit(d);
						frac_cnt++;
					end
				end else if (c == CH_EXP) begin
					ph = PH_ESKIP;
				end else begin
					close_number(c);
				end
			end
			PH_ESKIP: ph = PH_EXP;
			PH_EXP: begin
				if (is_dig) begin
					e       = exp_val * 8'd10 + 8'(d);
					exp_val = (e > 8'(MAX_EXPONENT)) ? MAX_EXPONENT : e[4:0];
				end else begin
					close_number(c);
				end
			end
			default: close_number(c);
		endcase
	endtask

	// Result checker and input monitor, sampled at the clock edge
	always @(posedge clk) begin
		number_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				numbers_seen++;
				if (expected_numbers.size() == 0) begin
					$error("unexpected word: value %h end_char %h",
						m_axis_tdata[31:0], m_axis_tdata[39:32]);
					errors++;
				end else begin
					want = expected_numbers.pop_front();
					if (m_axis_tdata[31:0] !== want.value) begin
						$error("value: expected %h, got %h", want.value,
							m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tuser !== want.saturated) begin
						$error("saturated: expected %b, got %b", want.saturated,
							m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[39:32] !== want.end_char) begin
						$error("end_char: expected %h, got %h", want.end_char,
							m_axis_tdata[39:32]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				parse_char(s_axis_tdata);
		end
	end

	// Watchdog on cycles where no word moves
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stall bursts until the calm stretch
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Send one character, with an optional idle burst before it
	task automatic send_char(input logic [7:0] c);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] pick_space(input int i);
		case (i)
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_LF;
			3:       return CH_VT;
			4:       return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Idle the sender until every expected number is back, then let the unit settle
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Ordinary integers and fractions, both clamp edges
	task automatic test_plain_numbers();
		send_text("0 +7,-1;32767.99999 -32768 32768 ");
	endtask

	// Whitespace, NUL end, bare sign or dot, leading dot, odd end characters
	task automatic test_whitespace_and_signs();
		for (int i = 0; i < 6; i++)
			send_char(pick_space(i));
		send_char(CH_ZERO + 8'd5);
		send_char(CH_NUL);
		send_text("- +x.5 . 3E9");
		send_char(8'hFF);
	endtask

	// Long fraction, exponent saturation, empty exponent, any skipped character
	task automatic test_fraction_and_exponent();
		send_text("0.1234567890123456789012 1.5E+99 2.5E+ 1.0Ex3 12.E-4 ");
	endtask

	// Mantissa overflow and magnitudes just past the signed range
	task automatic test_overflow_and_clamp();
		send_text("99999999999999999999999 -18446744073709551616 ");
		send_text("-32768.00001 -18446744073709551615.0E+15 ");
	endtask

	// One well-formed number with random content and a random end character
	task automatic send_random_number();
		int n_int;
		int n_frac;
		int r;
		repeat ($urandom_range(0, 2)) send_char(pick_space($urandom_range(0, 5)));
		r = $urandom_range(0, 3);
		if (r == 0)
			send_char(CH_MINUS);
		else if (r == 1)
			send_char(CH_PLUS);
		n_int = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 22)
			: $urandom_range(0, 5);
		repeat (n_int) send_char(pick_digit());
		if ($urandom_range(0, 9) < 7) begin
			send_char(CH_DOT);
			n_frac = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 22)
				: $urandom_range(0, 6);
			repeat (n_frac) send_char(pick_digit());
			if ($urandom_range(0, 2) == 0) begin
				send_char(CH_EXP);
				r = $urandom_range(0, 3);
				send_char(r == 0 ? CH_MINUS : r == 1 ? CH_PLUS
					: 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 3)) send_char(pick_digit());
			end
		end
		r = $urandom_range(0, 3);
		send_char(r == 0 ? CH_SPACE : r == 1 ? CH_SEMI : 8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed numbers, some raw noise bytes, calm at the end
	task automatic test_random_text();
		while (chars_used < TEXT_CHARS) begin
			if (chars_used >= TEXT_CHARS - CALM_CHARS)
				calm = 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
			else
				send_random_number();
		end
	endtask

	// Test sequence
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_numbers();
		test_whitespace_and_signs();
		test_fraction_and_exponent();
		test_overflow_and_clamp();
		hold_until_drained();
		test_random_text();
		// close any number still open, even one waiting on its skipped character
		send_text("; ");
		hold_until_drained();

		$display("checked %0d numbers from %0d characters, %0d saturated",
			numbers_seen, chars_used, sat_count);
		$display("largest divide depth: %0d powers of ten", deepest_k);
		if (errors == 0 && expected_numbers.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
